// ===== design/life_grid_generation_engine_core_assert.svh =====
// Assertion macros for the Life grid engine.
// LGGE_ASSERT_IMP checks a same-cycle implication, LGGE_ASSERT_NXT a next-cycle one.
// Both sample on clock and are disabled while reset is high.
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_ASSERT_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LGGE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgge: implication check failed");
`define LGGE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgge: next-cycle check failed");
`else
`define LGGE_ASSERT_IMP(label, ante, cons)
`define LGGE_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== design/lgge_pkg.sv =====
`default_nettype none

package lgge_pkg;

   localparam int ROW_W      = 64;
   localparam int IDX_W      = 6;
   localparam int GEOM_W     = 7;
   localparam int GEN_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int NB_CNT_W   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_COUNT = 2'd2;

   localparam logic [GEOM_W-1:0] GRID_ROWS_RST = 7'd64;
   localparam logic [GEOM_W-1:0] GRID_COLS_RST = 7'd64;
   localparam logic [GEN_W-1:0]  GEN_COUNT_RST = 16'd1;

   // smallest legal grid edge
   localparam int MIN_DIM = 3;

   // neighbor counts of the B3/S23 rule
   localparam logic [NB_CNT_W-1:0] NB_BIRTH = 4'd3;
   localparam logic [NB_CNT_W-1:0] NB_KEEP  = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPUTE = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== design/lgge_grid_mem.sv =====
`default_nettype none

module lgge_grid_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/lgge_row_unit.sv =====
`default_nettype none

module lgge_row_unit #(
   parameter int MAX_COLS = 64
) (
   input  wire logic [MAX_COLS-1:0]       up_row,
   input  wire logic [MAX_COLS-1:0]       cur_row,
   input  wire logic [MAX_COLS-1:0]       dn_row,
   input  wire logic [lgge_pkg::GEOM_W-1:0] eff_cols,
   input  wire logic [MAX_COLS-1:0]       col_mask,
   output logic      [MAX_COLS-1:0]       next_row
);

   localparam int CIW = $clog2(MAX_COLS);

   logic [CIW-1:0] top_col;

   // column j takes column j-1, column 0 takes the top used column
   function automatic logic [MAX_COLS-1:0] from_left(input logic [MAX_COLS-1:0] x,
                                                     input logic [CIW-1:0] top);
      return {x[MAX_COLS-2:0], x[top]};
   endfunction

   // column j takes column j+1, the top used column takes column 0
   function automatic logic [MAX_COLS-1:0] from_right(input logic [MAX_COLS-1:0] x,
                                                      input logic [CIW-1:0] top);
      logic [MAX_COLS-1:0] r;
      r      = {1'b0, x[MAX_COLS-1:1]};
      r[top] = x[0];
      return r;
   endfunction

   assign top_col = CIW'(eff_cols - lgge_pkg::GEOM_W'(1));

   always_comb begin
      logic [MAX_COLS-1:0] ul, ur, cl, cr, dl, dr;
      logic [lgge_pkg::NB_CNT_W-1:0] cnt;
      ul = from_left(up_row, top_col);
      ur = from_right(up_row, top_col);
      cl = from_left(cur_row, top_col);
      cr = from_right(cur_row, top_col);
      dl = from_left(dn_row, top_col);
      dr = from_right(dn_row, top_col);
      for (int j = 0; j < MAX_COLS; j++) begin
         cnt = lgge_pkg::NB_CNT_W'(ul[j]) + lgge_pkg::NB_CNT_W'(up_row[j])
             + lgge_pkg::NB_CNT_W'(ur[j]) + lgge_pkg::NB_CNT_W'(cl[j])
             + lgge_pkg::NB_CNT_W'(cr[j]) + lgge_pkg::NB_CNT_W'(dl[j])
             + lgge_pkg::NB_CNT_W'(dn_row[j]) + lgge_pkg::NB_CNT_W'(dr[j]);
         next_row[j] = col_mask[j]
                     & ((cnt == lgge_pkg::NB_BIRTH)
                        | ((cnt == lgge_pkg::NB_KEEP) & cur_row[j]));
      end
   end

endmodule

`default_nettype wire

// ===== design/life_grid_generation_engine_core.sv =====
// Toroidal Life engine (B3/S23) over a grid of up to MAX_ROWS x MAX_COLS one-bit cells.
// Request channel (req_valid / req_stall): one packed row per transfer, bit c is column c.
// Rows fill the grid from row 0; a transfer with req_last_row_in set ends the load and
// starts the run; req_stall is low throughout the load.
// The run computes generation_count generations, one grid row per cycle through a single
// shared row unit against one grid memory.
// Then the final grid leaves on the response channel (rsp_valid / rsp_stall), one row per
// transfer with its index, and rsp_last_row_out set on the last row. req_stall stays high
// from the end of the load until the last row has entered the response register.
// A stalled response holds its row; the memory read ahead waits in one staging register.
// Write csr_* (0 grid_rows, 1 grid_cols, 2 generation_count) only while idle.
// Geometry is clamped to [3, MAX_ROWS] and [3, MAX_COLS]; column bits above the
// column count are cleared.
// Reset (synchronous): 64 x 64 grid, one generation, load pointer at row 0, no response
// pending. Grid contents are not cleared.
`default_nettype none

`include "life_grid_generation_engine_core_assert.svh"

module life_grid_generation_engine_core #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               csr_wr_en,
   input  wire logic [lgge_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lgge_pkg::CSR_DATA_W-1:0]    csr_wdata,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [lgge_pkg::ROW_W-1:0]         req_row_cells,
   input  wire logic                               req_last_row_in,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [lgge_pkg::ROW_W-1:0]         rsp_result_row_cells,
   output logic      [lgge_pkg::IDX_W-1:0]         rsp_result_row_index,
   output logic                                    rsp_last_row_out
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int KW = $clog2(MAX_ROWS + 3);
   localparam int GW = lgge_pkg::GEOM_W;
   localparam int NW = lgge_pkg::GEN_W;

   // configuration
   logic [GW-1:0] grid_rows_ff, grid_cols_ff;
   logic [NW-1:0] gen_count_ff;

   // sequencer
   lgge_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       load_ptr_ff, load_ptr_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [KW-1:0]       e_ff, e_in;
   logic [NW-1:0]       gen_ff, gen_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;

   // geometry latched for the run
   logic [KW-1:0]       rows_ff, rows_in;
   logic [AW-1:0]       last_idx_ff, last_idx_in;
   logic [GW-1:0]       cols_ff, cols_in;
   logic [MAX_COLS-1:0] mask_ff, mask_in;
   logic [NW-1:0]       gen_tgt_ff, gen_tgt_in;

   // row window
   logic [MAX_COLS-1:0] up_ff, up_in, cur_ff, cur_in, row0_ff, row0_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [lgge_pkg::ROW_W-1:0] rsp_cells_ff, rsp_cells_in;
   logic [lgge_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                      rsp_last_ff, rsp_last_in;

   // live geometry
   logic [KW-1:0]       eff_rows;
   logic [GW-1:0]       eff_cols;
   logic [MAX_COLS-1:0] mask_live;

   // memory port and row unit
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [MAX_COLS-1:0] mem_wdata, mem_rdata, rd_masked, dn_row, nxt_row;
   logic                final_step, out_load, issue;

   always_comb begin
      if (32'(grid_rows_ff) > MAX_ROWS) begin
         eff_rows = KW'(MAX_ROWS);
      end else if (32'(grid_rows_ff) < lgge_pkg::MIN_DIM) begin
         eff_rows = KW'(lgge_pkg::MIN_DIM);
      end else begin
         eff_rows = KW'(grid_rows_ff);
      end
      if (32'(grid_cols_ff) > MAX_COLS) begin
         eff_cols = GW'(MAX_COLS);
      end else if (32'(grid_cols_ff) < lgge_pkg::MIN_DIM) begin
         eff_cols = GW'(lgge_pkg::MIN_DIM);
      end else begin
         eff_cols = grid_cols_ff;
      end
      for (int j = 0; j < MAX_COLS; j++) begin
         mask_live[j] = (j < int'(eff_cols));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= lgge_pkg::GRID_ROWS_RST;
         grid_cols_ff <= lgge_pkg::GRID_COLS_RST;
         gen_count_ff <= lgge_pkg::GEN_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lgge_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[GW-1:0];
            lgge_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata[GW-1:0];
            lgge_pkg::CSR_GEN_COUNT: gen_count_ff <= csr_wdata[NW-1:0];
            default: ;
         endcase
      end
   end

   lgge_grid_mem #(
      .DEPTH(MAX_ROWS),
      .WIDTH(MAX_COLS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign rd_masked  = mem_rdata & mask_ff;
   assign final_step = (k_ff == rows_ff + KW'(2));
   assign dn_row     = final_step ? row0_ff : rd_masked;

   lgge_row_unit #(
      .MAX_COLS(MAX_COLS)
   ) u_row (
      .up_row  (up_ff),
      .cur_row (cur_ff),
      .dn_row  (dn_row),
      .eff_cols(cols_ff),
      .col_mask(mask_ff),
      .next_row(nxt_row)
   );

   assign out_load = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue    = (e_ff < rows_ff) && (!pend_ff || out_load);

   always_comb begin
      state_in    = state_ff;
      load_ptr_in = load_ptr_ff;
      k_in        = k_ff;
      e_in        = e_ff;
      gen_in      = gen_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      rows_in     = rows_ff;
      last_idx_in = last_idx_ff;
      cols_in     = cols_ff;
      mask_in     = mask_ff;
      gen_tgt_in  = gen_tgt_ff;
      up_in       = up_ff;
      cur_in      = cur_ff;
      row0_in     = row0_ff;
      mem_we      = 1'b0;
      mem_waddr   = load_ptr_ff;
      mem_wdata   = MAX_COLS'(req_row_cells) & mask_live;
      mem_re      = 1'b0;
      mem_raddr   = AW'(e_ff);

      case (state_ff)
         lgge_pkg::ST_IDLE: begin
            if (req_valid) begin
               mem_we = 1'b1;
               if (load_ptr_ff == AW'(MAX_ROWS - 1)) begin
                  load_ptr_in = '0;
               end else begin
                  load_ptr_in = load_ptr_ff + AW'(1);
               end
               if (req_last_row_in) begin
                  load_ptr_in = '0;
                  rows_in     = eff_rows;
                  last_idx_in = AW'(eff_rows - KW'(1));
                  cols_in     = eff_cols;
                  mask_in     = mask_live;
                  gen_tgt_in  = gen_count_ff;
                  k_in        = '0;
                  e_in        = '0;
                  gen_in      = '0;
                  if (gen_count_ff == '0) begin
                     state_in = lgge_pkg::ST_EMIT;
                  end else begin
                     state_in = lgge_pkg::ST_COMPUTE;
                  end
               end
            end
         end

         lgge_pkg::ST_COMPUTE: begin
            // read order: last row, then rows 0 .. last; row 0 is saved before overwrite
            if (k_ff <= rows_ff) begin
               mem_re = 1'b1;
               if (k_ff == '0) begin
                  mem_raddr = last_idx_ff;
               end else begin
                  mem_raddr = AW'(k_ff - KW'(1));
               end
            end
            if (k_ff >= KW'(1) && k_ff <= rows_ff + KW'(1)) begin
               up_in  = cur_ff;
               cur_in = rd_masked;
            end
            if (k_ff == KW'(2)) begin
               row0_in = rd_masked;
            end
            if (k_ff >= KW'(3) && k_ff <= rows_ff + KW'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(k_ff - KW'(3));
               mem_wdata = nxt_row;
            end
            if (final_step) begin
               mem_we    = 1'b1;
               mem_waddr = last_idx_ff;
               mem_wdata = nxt_row;
               k_in      = '0;
               if (gen_ff + NW'(1) == gen_tgt_ff) begin
                  state_in = lgge_pkg::ST_EMIT;
               end else begin
                  gen_in = gen_ff + NW'(1);
               end
            end else begin
               k_in = k_ff + KW'(1);
            end
         end

         lgge_pkg::ST_EMIT: begin
            if (issue) begin
               mem_re      = 1'b1;
               mem_raddr   = AW'(e_ff);
               e_in        = e_ff + KW'(1);
               pend_in     = 1'b1;
               pend_idx_in = AW'(e_ff);
            end else if (out_load) begin
               pend_in = 1'b0;
            end
            if (e_ff == rows_ff && !pend_ff) begin
               state_in = lgge_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lgge_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cells_in = rsp_cells_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_cells_in = lgge_pkg::ROW_W'(rd_masked);
         rsp_idx_in   = lgge_pkg::IDX_W'(pend_idx_ff);
         rsp_last_in  = (pend_idx_ff == last_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgge_pkg::ST_IDLE;
         load_ptr_ff  <= '0;
         k_ff         <= '0;
         e_ff         <= '0;
         gen_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ptr_ff  <= load_ptr_in;
         k_ff         <= k_in;
         e_ff         <= e_in;
         gen_ff       <= gen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      rows_ff      <= rows_in;
      last_idx_ff  <= last_idx_in;
      cols_ff      <= cols_in;
      mask_ff      <= mask_in;
      gen_tgt_ff   <= gen_tgt_in;
      up_ff        <= up_in;
      cur_ff       <= cur_in;
      row0_ff      <= row0_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall            = (state_ff != lgge_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_row_cells = rsp_cells_ff;
   assign rsp_result_row_index = rsp_idx_ff;
   assign rsp_last_row_out     = rsp_last_ff;

   `LGGE_ASSERT_IMP(a_wr_in_grid, mem_we && state_ff == lgge_pkg::ST_COMPUTE, mem_waddr <= last_idx_ff)
   `LGGE_ASSERT_IMP(a_pend_in_emit, pend_ff, state_ff == lgge_pkg::ST_EMIT)
   `LGGE_ASSERT_IMP(a_rsp_from_pend, $rose(rsp_valid_ff), $past(pend_ff))
   `LGGE_ASSERT_NXT(a_pend_held, pend_ff && rsp_valid_ff && rsp_stall, pend_ff)
   `LGGE_ASSERT_IMP(a_gen_bound, state_ff == lgge_pkg::ST_COMPUTE, gen_ff < gen_tgt_ff)

endmodule

`default_nettype wire
